/* rtl/alu8f_pkg.sv */
// Shared types for the 8-bit ALU with flags: operation codes, flag set,
// input word and result word layouts. No dependencies.
package alu8f_pkg;

  // Operation selector carried on the input tuser
  typedef enum logic [4:0] {
    FN_ADD   = 5'd0,
    FN_ADC   = 5'd1,
    FN_SUB   = 5'd2,
    FN_SBC   = 5'd3,
    FN_AND   = 5'd4,
    FN_XOR   = 5'd5,
    FN_OR    = 5'd6,
    FN_CP    = 5'd7,
    FN_INC   = 5'd8,
    FN_DEC   = 5'd9,
    FN_RLC   = 5'd10,
    FN_RRC   = 5'd11,
    FN_RL    = 5'd12,
    FN_RR    = 5'd13,
    FN_SLA   = 5'd14,
    FN_SRA   = 5'd15,
    FN_SWAP  = 5'd16,
    FN_SRL   = 5'd17,
    FN_BIT   = 5'd18,
    FN_RES   = 5'd19,
    FN_SET   = 5'd20,
    FN_DAA   = 5'd21,
    FN_CPL   = 5'd22,
    FN_CCF   = 5'd23,
    FN_SCF   = 5'd24,
    FN_ADD16 = 5'd25,
    FN_ADDSP = 5'd26,
    FN_INC16 = 5'd27,
    FN_DEC16 = 5'd28
  } func_e;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 32;

  // Decimal adjust constants
  localparam logic [7:0] DaaLoAdj  = 8'h06;
  localparam logic [7:0] DaaHiAdj  = 8'h60;
  localparam logic [7:0] DaaHiLim  = 8'h99;
  localparam logic [3:0] DaaLoLim  = 4'd9;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    func_e              func;
    logic        [7:0]  acc_value;
    logic        [7:0]  operand;
    logic        [2:0]  bit_index;
    logic        [15:0] word_a;
    logic        [15:0] word_b;
    logic signed [7:0]  offset;
  } item_t;

  typedef struct packed {
    logic [7:0]  result_byte;
    logic [15:0] result_word;
    logic        write_back;
    flags_t      flags;
  } result_t;

endpackage

/* rtl/eight_bit_alu_with_flags_unit.sv */
// Top level of the 8-bit ALU with flags: input register, flag register,
// result register and stream handshakes. Depends on alu8f_pkg, alu8f_core.
//
//  channel | dir | tdata                                         | tuser
//  s_axis  | in  | acc[7:0] opnd[15:8] bit[18:16] wa[34:19]      | func[4:0]
//          |     | wb[50:35] offset[58:51], pad to 64            |
//  m_axis  | out | byte[7:0] word[23:8] wb[24] z[25] n[26]       | -
//          |     | h[27] c[28], pad to 32                        |
//
// One word per cycle sustained while m_axis does not stall; a taken word
// passes through the input register, then the result register, before it
// is offered on m_axis.
// Flags are updated when a word moves from the input register into the
// result register, so the next word always sees the previous word's flags.
// Reset clears both valid bits and the flags.
// When m_axis stalls, one word waits in the result register and one more
// can be taken into the input register before s_axis_tready drops.
module eight_bit_alu_with_flags_unit import alu8f_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // acc, operand, bit_index, word_a, word_b, offset
  input  logic [4:0]          s_axis_tuser,   // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // byte, word, write_back, z, n, h, c
);

  logic    in_valid_q;
  item_t   in_item_q, in_item_d;
  logic    out_valid_q;
  result_t out_res_q, core_res;
  flags_t  flags_q;
  logic    advance;
  logic    in_take;

  // Handshake
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  // Unpack input word
  assign in_item_d = '{func:      func_e'(s_axis_tuser),
                       acc_value: s_axis_tdata[7:0],
                       operand:   s_axis_tdata[15:8],
                       bit_index: s_axis_tdata[18:16],
                       word_a:    s_axis_tdata[34:19],
                       word_b:    s_axis_tdata[50:35],
                       offset:    s_axis_tdata[58:51]};

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_d;
    end
  end

  alu8f_core u_core (
    .item_i  (in_item_q),
    .flags_i (flags_q),
    .res_o   (core_res)
  );

  // Flag register and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        flags_q <= core_res.flags;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_res_q.flags.c, out_res_q.flags.h, out_res_q.flags.n,
                          out_res_q.flags.z, out_res_q.write_back,
                          out_res_q.result_word, out_res_q.result_byte};

  // Checks
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flags_q))
    else $error("flags changed without a word advancing");

  a_out_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_res_q.flags == flags_q))
    else $error("result flags differ from kept flags");

  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled while pipeline has room");

  a_word_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.result_word != 16'h0000) |-> !out_res_q.write_back)
    else $error("word result marked for byte write-back");

endmodule

/* rtl/alu8f_core.sv */
// Combinational datapath of the 8-bit ALU: one operation on one word.
// Depends on alu8f_pkg.
module alu8f_core import alu8f_pkg::*; (
  input  item_t   item_i,
  input  flags_t  flags_i,
  output result_t res_o
);

  logic [7:0]  a, v;
  logic        ci_add, ci_sub;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_half;
  logic [7:0]  inc_r, dec_r;
  logic [7:0]  bit_mask;
  logic        daa_lo, daa_hi;
  logic [7:0]  daa_adj, daa_r;
  logic [16:0] w_sum;
  logic [12:0] w_half;
  logic [15:0] sp_sum;
  logic [4:0]  sp_half;
  logic [8:0]  sp_low;
  logic [7:0]  r;
  logic [15:0] w;
  logic        wr;
  flags_t      f;

  assign a = item_i.acc_value;
  assign v = item_i.operand;

  // 8-bit add / subtract with nibble carry
  assign ci_add   = (item_i.func == FN_ADC) & flags_i.c;
  assign ci_sub   = (item_i.func == FN_SBC) & flags_i.c;
  assign add_sum  = {1'b0, a} + {1'b0, v} + {8'd0, ci_add};
  assign add_half = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, ci_add};
  assign sub_diff = {1'b0, a} - {1'b0, v} - {8'd0, ci_sub};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, ci_sub};
  assign inc_r    = v + 8'd1;
  assign dec_r    = v - 8'd1;
  assign bit_mask = 8'd1 << item_i.bit_index;

  // Decimal adjust: correction depends on the last op's N/H/C
  always_comb begin
    if (!flags_i.n) begin
      daa_lo = flags_i.h | (a[3:0] > DaaLoLim);
      daa_hi = flags_i.c | (a > DaaHiLim);
    end else begin
      daa_lo = flags_i.h;
      daa_hi = flags_i.c;
    end
    daa_adj = (daa_lo ? DaaLoAdj : 8'h00) | (daa_hi ? DaaHiAdj : 8'h00);
    daa_r   = flags_i.n ? (a - daa_adj) : (a + daa_adj);
  end

  // 16-bit adds
  assign w_sum   = {1'b0, item_i.word_a} + {1'b0, item_i.word_b};
  assign w_half  = {1'b0, item_i.word_a[11:0]} + {1'b0, item_i.word_b[11:0]};
  assign sp_sum  = item_i.word_a + {{8{item_i.offset[7]}}, item_i.offset};
  assign sp_half = {1'b0, item_i.word_a[3:0]} + {1'b0, item_i.offset[3:0]};
  assign sp_low  = {1'b0, item_i.word_a[7:0]} + {1'b0, item_i.offset};

  // Result and flag select
  always_comb begin
    r  = 8'h00;
    w  = 16'h0000;
    wr = 1'b1;
    f  = flags_i;
    case (item_i.func)
      FN_ADD, FN_ADC: begin
        r = add_sum[7:0];
        f = '{z: (add_sum[7:0] == 8'h00), n: 1'b0, h: add_half[4], c: add_sum[8]};
      end
      FN_SUB, FN_SBC, FN_CP: begin
        r = sub_diff[7:0];
        f = '{z: (sub_diff[7:0] == 8'h00), n: 1'b1, h: sub_half[4], c: sub_diff[8]};
        if (item_i.func == FN_CP) begin
          r  = a;
          wr = 1'b0;
        end
      end
      FN_AND: begin
        r = a & v;
        f = '{z: ((a & v) == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      FN_XOR: begin
        r = a ^ v;
        f = '{z: ((a ^ v) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      FN_OR: begin
        r = a | v;
        f = '{z: ((a | v) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      FN_INC: begin
        r = inc_r;
        f = '{z: (inc_r == 8'h00), n: 1'b0, h: (v[3:0] == 4'hF), c: flags_i.c};
      end
      FN_DEC: begin
        r = dec_r;
        f = '{z: (dec_r == 8'h00), n: 1'b1, h: (v[3:0] == 4'h0), c: flags_i.c};
      end
      FN_RLC: begin
        r = {v[6:0], v[7]};
        f = '{z: (v == 8'h00), n: 1'b0, h: 1'b0, c: v[7]};
      end
      FN_RRC: begin
        r = {v[0], v[7:1]};
        f = '{z: (v == 8'h00), n: 1'b0, h: 1'b0, c: v[0]};
      end
      FN_RL: begin
        r = {v[6:0], flags_i.c};
        f = '{z: ({v[6:0], flags_i.c} == 8'h00), n: 1'b0, h: 1'b0, c: v[7]};
      end
      FN_RR: begin
        r = {flags_i.c, v[7:1]};
        f = '{z: ({flags_i.c, v[7:1]} == 8'h00), n: 1'b0, h: 1'b0, c: v[0]};
      end
      FN_SLA: begin
        r = {v[6:0], 1'b0};
        f = '{z: (v[6:0] == 7'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      FN_SRA: begin
        r = {v[7], v[7:1]};
        f = '{z: (v[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      FN_SWAP: begin
        r = {v[3:0], v[7:4]};
        f = '{z: (v == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      FN_SRL: begin
        r = {1'b0, v[7:1]};
        f = '{z: (v[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      FN_BIT: begin
        r  = v;
        wr = 1'b0;
        f  = '{z: ((v & bit_mask) == 8'h00), n: 1'b0, h: 1'b1, c: flags_i.c};
      end
      FN_RES: r = v & ~bit_mask;
      FN_SET: r = v | bit_mask;
      FN_DAA: begin
        r = daa_r;
        f = '{z: (daa_r == 8'h00), n: flags_i.n, h: 1'b0,
              c: flags_i.c | (~flags_i.n & daa_hi)};
      end
      FN_CPL: begin
        r = ~a;
        f = '{z: flags_i.z, n: 1'b1, h: 1'b1, c: flags_i.c};
      end
      FN_CCF: begin
        r  = a;
        wr = 1'b0;
        f  = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: ~flags_i.c};
      end
      FN_SCF: begin
        r  = a;
        wr = 1'b0;
        f  = '{z: flags_i.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      FN_ADD16: begin
        w  = w_sum[15:0];
        wr = 1'b0;
        f  = '{z: flags_i.z, n: 1'b0, h: w_half[12], c: w_sum[16]};
      end
      FN_ADDSP: begin
        w  = sp_sum;
        wr = 1'b0;
        f  = '{z: 1'b0, n: 1'b0, h: sp_half[4], c: sp_low[8]};
      end
      FN_INC16: begin
        w  = item_i.word_a + 16'd1;
        wr = 1'b0;
      end
      FN_DEC16: begin
        w  = item_i.word_a - 16'd1;
        wr = 1'b0;
      end
      default: wr = 1'b0; // unassigned codes: no-op
    endcase
  end

  assign res_o = '{result_byte: r, result_word: w, write_back: wr, flags: f};

endmodule
